@@ src/nsp_pkg.sv @@
// ----------------------------------------------------------------------------
// nsp_pkg: shared constants and tables of the phase-shift pixel core
// Coefficient tables, arctangent table, datapath widths and register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package nsp_pkg;

    localparam int SAMPLE_W        = 8;
    localparam int NUM_SAMPLES     = 8;
    localparam int COEF_W          = 16;
    localparam int PROD_W          = 25;
    localparam int SUM_W           = 28;
    localparam int MAG_W           = 26;
    localparam int SQ_W            = 52;
    localparam int XY_W            = 56;
    localparam int ANG_W           = 32;
    localparam int CORDIC_PRESHIFT = 26;
    localparam int CORDIC_ITERS    = 30;
    localparam int SQRT_CELLS      = 26;
    localparam int SQRT_TOP_BIT    = 50;
    localparam int MOD_W           = 13;
    localparam int STEP_W          = 4;
    localparam int ROW_W           = 3;
    localparam int CFG_IDX_W       = 4;
    localparam int CFG_DATA_W      = 8;
    localparam int RECIP_SHIFT     = 20;
    localparam int RECIP_W         = 19;
    localparam int QUO_W           = 18;
    localparam int RPROD_W         = QUO_W + RECIP_W;

    localparam logic [MOD_W-1:0]     MOD_TOP        = 13'd8191;
    localparam logic [STEP_W-1:0]    STEP_MIN       = 4'd3;
    localparam logic [STEP_W-1:0]    STEP_RESET     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOD_ENABLE = 4'd1;
    localparam logic [ANG_W-1:0]     HALF_TURN      = 32'h8000_0000;

    typedef logic signed [COEF_W-1:0] t_coef;

    typedef struct packed {
        logic [STEP_W-1:0] n_steps;
        logic              mod_en;
        logic              zero;
    } t_side;

    // Rows are indexed by step count minus three; the last two rows are never selected.
    localparam t_coef SIN_TAB [8][8] = '{
        '{16'sd0, 16'sd14189, -16'sd14189, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{16'sd0, 16'sd16384, 16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{16'sd0, 16'sd15582, 16'sd9630, -16'sd9630, -16'sd15582, 16'sd0, 16'sd0, 16'sd0},
        '{16'sd0, 16'sd14189, 16'sd14189, 16'sd0, -16'sd14189, -16'sd14189, 16'sd0,
          16'sd0},
        '{16'sd0, 16'sd12810, 16'sd15973, 16'sd7109, -16'sd7109, -16'sd15973, -16'sd12810,
          16'sd0},
        '{16'sd0, 16'sd11585, 16'sd16384, 16'sd11585, 16'sd0, -16'sd11585, -16'sd16384,
          -16'sd11585},
        '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}
    };

    localparam t_coef COS_TAB [8][8] = '{
        '{16'sd16384, -16'sd8192, -16'sd8192, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{16'sd16384, 16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{16'sd16384, 16'sd5063, -16'sd13255, -16'sd13255, 16'sd5063, 16'sd0, 16'sd0,
          16'sd0},
        '{16'sd16384, 16'sd8192, -16'sd8192, -16'sd16384, -16'sd8192, 16'sd8192, 16'sd0,
          16'sd0},
        '{16'sd16384, 16'sd10215, -16'sd3646, -16'sd14761, -16'sd14761, -16'sd3646,
          16'sd10215, 16'sd0},
        '{16'sd16384, 16'sd11585, 16'sd0, -16'sd11585, -16'sd16384, -16'sd11585, 16'sd0,
          16'sd11585},
        '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}
    };

    localparam logic [ANG_W-1:0] ATAN_TAB [CORDIC_ITERS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    // floor(2^20 / n); the quotient estimate from it is low by at most one.
    function automatic logic [RECIP_W-1:0] recip(input logic [STEP_W-1:0] n);
        logic [RECIP_W-1:0] r;
        unique case (n)
            4'd3:    r = 19'd349525;
            4'd4:    r = 19'd262144;
            4'd5:    r = 19'd209715;
            4'd6:    r = 19'd174762;
            4'd7:    r = 19'd149796;
            default: r = 19'd131072;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ src/n_step_phase_shift_pixel_core.sv @@
// ----------------------------------------------------------------------------
// n_step_phase_shift_pixel_core: wrapped phase and modulation of one pixel
// Weighted sine and cosine sums, arctangent chain and magnitude chain.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries one pixel per beat: its eight
//   image intensities. Output channel (o_valid / i_stall) carries one result
//   per beat: wrapped phase and modulation. The configuration channel
//   (i_cfg_valid / o_cfg_ready, always ready) writes step count (index 0)
//   and modulation enable (index 1); write it only while the block is empty.
//   Throughput is one pixel per cycle while the receiver does not stall. The
//   stages, in order: input register, products, sums, setup, thirty cells
//   of the arctangent chain (the modulation path, a 26-cell root chain plus
//   a division by the step count in product, estimate and clamp registers,
//   runs alongside), and the output register.
//   Every stage holds one beat and moves on whenever the next stage is
//   empty or moving, so a stalled receiver holds the result at the output
//   while bubbles ahead of it still fill; o_stall rises only once every stage
//   is full. Reset empties the pipeline and sets step count 4, modulation off.
// ----------------------------------------------------------------------------
`default_nettype none

module n_step_phase_shift_pixel_core #(
    parameter int MAX_STEPS  = 8,
    parameter int PHASE_BITS = 16
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_valid,
    output logic                                   o_stall,
    input  wire logic [nsp_pkg::SAMPLE_W-1:0]      i_sample_0,
    input  wire logic [nsp_pkg::SAMPLE_W-1:0]      i_sample_1,
    input  wire logic [nsp_pkg::SAMPLE_W-1:0]      i_sample_2,
    input  wire logic [nsp_pkg::SAMPLE_W-1:0]      i_sample_3,
    input  wire logic [nsp_pkg::SAMPLE_W-1:0]      i_sample_4,
    input  wire logic [nsp_pkg::SAMPLE_W-1:0]      i_sample_5,
    input  wire logic [nsp_pkg::SAMPLE_W-1:0]      i_sample_6,
    input  wire logic [nsp_pkg::SAMPLE_W-1:0]      i_sample_7,
    output logic                                   o_valid,
    input  wire                                    i_stall,
    output logic [PHASE_BITS-1:0]                  o_wrapped_phase,
    output logic [nsp_pkg::MOD_W-1:0]              o_modulation,
    input  wire                                    i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [nsp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [nsp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int NS         = nsp_pkg::NUM_SAMPLES;
    localparam int ST_PROD    = 1;
    localparam int ST_SUM     = 2;
    localparam int ST_INIT    = 3;
    localparam int ST_SQSUM   = 4;
    localparam int ST_SQRT0   = 5;
    localparam int ST_MUL     = ST_SQRT0 + nsp_pkg::SQRT_CELLS;
    localparam int ST_EST     = ST_MUL + 1;
    localparam int ST_MOD     = ST_EST + 1;
    localparam int ST_OUT     = ST_INIT + 1 + nsp_pkg::CORDIC_ITERS;
    localparam int STAGES     = ST_OUT + 1;
    localparam logic [nsp_pkg::STEP_W-1:0] STEP_MAX = nsp_pkg::STEP_W'(MAX_STEPS);
    localparam logic [nsp_pkg::ANG_W-1:0]  ROUND_HALF =
        nsp_pkg::ANG_W'(1) << (nsp_pkg::ANG_W - PHASE_BITS - 1);

    // Configuration registers.
    logic [nsp_pkg::STEP_W-1:0] r_step_count;
    logic                       r_mod_en;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_count <= nsp_pkg::STEP_RESET;
            r_mod_en     <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                nsp_pkg::REG_STEP_COUNT: r_step_count <= i_cfg_data[nsp_pkg::STEP_W-1:0];
                nsp_pkg::REG_MOD_ENABLE: r_mod_en     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Stage control: a stage loads when it is empty or its successor loads.
    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] n_vld;
    logic [STAGES-1:0] ld;

    assign ld[STAGES-1] = !r_vld[STAGES-1] || !i_stall;

    for (genvar s = 0; s < STAGES - 1; s++) begin : g_ld
        assign ld[s] = !r_vld[s] || ld[s+1];
    end

    always_comb begin
        n_vld = r_vld;
        if (ld[0]) n_vld[0] = i_valid;
        for (int s = 1; s < STAGES; s++) begin
            if (ld[s]) n_vld[s] = r_vld[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_stall = !ld[0];
    assign o_valid = r_vld[STAGES-1];

    // Sideband that travels with every beat.
    nsp_pkg::t_side            r_side [STAGES];
    logic [nsp_pkg::STEP_W-1:0] n_steps_in;

    always_comb begin
        if (r_step_count < nsp_pkg::STEP_MIN) begin
            n_steps_in = nsp_pkg::STEP_MIN;
        end else if (r_step_count > STEP_MAX) begin
            n_steps_in = STEP_MAX;
        end else begin
            n_steps_in = r_step_count;
        end
    end

    // Input stage.
    logic [nsp_pkg::SAMPLE_W-1:0] r_smp [NS];

    always_ff @(posedge i_clk) begin
        if (ld[0]) begin
            r_smp[0]  <= i_sample_0;
            r_smp[1]  <= i_sample_1;
            r_smp[2]  <= i_sample_2;
            r_smp[3]  <= i_sample_3;
            r_smp[4]  <= i_sample_4;
            r_smp[5]  <= i_sample_5;
            r_smp[6]  <= i_sample_6;
            r_smp[7]  <= i_sample_7;
            r_side[0] <= '{n_steps: n_steps_in, mod_en: r_mod_en, zero: 1'b0};
        end
    end

    // Products with the coefficient row of the step count in use.
    logic signed [nsp_pkg::PROD_W-1:0] r_ps [NS];
    logic signed [nsp_pkg::PROD_W-1:0] r_pc [NS];
    logic [nsp_pkg::ROW_W-1:0]         row;

    assign row = nsp_pkg::ROW_W'(r_side[0].n_steps - nsp_pkg::STEP_MIN);

    for (genvar n = 0; n < NS; n++) begin : g_prod
        logic signed [nsp_pkg::SAMPLE_W:0] s_ext;
        logic signed [nsp_pkg::PROD_W-1:0] p_s;
        logic signed [nsp_pkg::PROD_W-1:0] p_c;
        logic                              in_use;

        assign s_ext  = $signed({1'b0, r_smp[n]});
        assign in_use = nsp_pkg::STEP_W'(n) < r_side[0].n_steps;
        assign p_s    = s_ext * nsp_pkg::SIN_TAB[row][n];
        assign p_c    = s_ext * nsp_pkg::COS_TAB[row][n];

        always_ff @(posedge i_clk) begin
            if (ld[ST_PROD]) begin
                r_ps[n] <= in_use ? p_s : '0;
                r_pc[n] <= in_use ? p_c : '0;
            end
        end
    end

    // Sums M and D.
    logic signed [nsp_pkg::SUM_W-1:0] n_m;
    logic signed [nsp_pkg::SUM_W-1:0] n_d;
    logic signed [nsp_pkg::SUM_W-1:0] r_m;
    logic signed [nsp_pkg::SUM_W-1:0] r_d;

    always_comb begin
        n_m = '0;
        n_d = '0;
        for (int n = 0; n < NS; n++) begin
            n_m = n_m + nsp_pkg::SUM_W'(r_ps[n]);
            n_d = n_d + nsp_pkg::SUM_W'(r_pc[n]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld[ST_SUM]) begin
            r_m <= n_m;
            r_d <= n_d;
        end
    end

    // Setup: scaled vector with half-turn pre-rotation, and the squares.
    logic signed [nsp_pkg::XY_W-1:0] x0;
    logic signed [nsp_pkg::XY_W-1:0] y0;
    logic [nsp_pkg::MAG_W-1:0]       um;
    logic [nsp_pkg::MAG_W-1:0]       ud;
    logic signed [nsp_pkg::XY_W-1:0] r_x3;
    logic signed [nsp_pkg::XY_W-1:0] r_y3;
    logic [nsp_pkg::ANG_W-1:0]       r_a3;
    logic [nsp_pkg::SQ_W-1:0]        r_um2;
    logic [nsp_pkg::SQ_W-1:0]        r_ud2;

    always_comb begin
        x0 = nsp_pkg::XY_W'(r_d) <<< nsp_pkg::CORDIC_PRESHIFT;
        y0 = -(nsp_pkg::XY_W'(r_m) <<< nsp_pkg::CORDIC_PRESHIFT);
        um = nsp_pkg::MAG_W'(r_m[nsp_pkg::SUM_W-1] ? -r_m : r_m);
        ud = nsp_pkg::MAG_W'(r_d[nsp_pkg::SUM_W-1] ? -r_d : r_d);
    end

    always_ff @(posedge i_clk) begin
        if (ld[ST_INIT]) begin
            if (r_d[nsp_pkg::SUM_W-1]) begin
                r_x3 <= -x0;
                r_y3 <= -y0;
                r_a3 <= nsp_pkg::HALF_TURN;
            end else begin
                r_x3 <= x0;
                r_y3 <= y0;
                r_a3 <= '0;
            end
            r_um2 <= nsp_pkg::SQ_W'(um * um);
            r_ud2 <= nsp_pkg::SQ_W'(ud * ud);
        end
    end

    for (genvar s = 1; s < STAGES; s++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (ld[s]) begin
                if (s == ST_INIT) begin
                    r_side[s] <= '{n_steps: r_side[s-1].n_steps,
                                   mod_en:  r_side[s-1].mod_en,
                                   zero:    (r_m == '0) && (r_d == '0)};
                end else begin
                    r_side[s] <= r_side[s-1];
                end
            end
        end
    end

    // Arctangent chain.
    logic signed [nsp_pkg::XY_W-1:0] cx  [nsp_pkg::CORDIC_ITERS+1];
    logic signed [nsp_pkg::XY_W-1:0] cy  [nsp_pkg::CORDIC_ITERS+1];
    logic [nsp_pkg::ANG_W-1:0]       ca  [nsp_pkg::CORDIC_ITERS+1];

    assign cx[0] = r_x3;
    assign cy[0] = r_y3;
    assign ca[0] = r_a3;

    for (genvar i = 0; i < nsp_pkg::CORDIC_ITERS; i++) begin : g_cordic
        nsp_cordic_cell #(.SHIFT(i)) u_cell (
            .i_clk (i_clk),
            .i_ld  (ld[ST_INIT+1+i]),
            .i_x   (cx[i]),
            .i_y   (cy[i]),
            .i_ang (ca[i]),
            .o_x   (cx[i+1]),
            .o_y   (cy[i+1]),
            .o_ang (ca[i+1])
        );
    end

    // Magnitude chain.
    logic [nsp_pkg::SQ_W-1:0] r_v4;
    logic [nsp_pkg::SQ_W-1:0] sv [nsp_pkg::SQRT_CELLS+1];
    logic [nsp_pkg::SQ_W-1:0] sr [nsp_pkg::SQRT_CELLS+1];

    always_ff @(posedge i_clk) begin
        if (ld[ST_SQSUM]) r_v4 <= r_um2 + r_ud2;
    end

    assign sv[0] = r_v4;
    assign sr[0] = '0;

    for (genvar j = 0; j < nsp_pkg::SQRT_CELLS; j++) begin : g_sqrt
        nsp_sqrt_cell #(.BIT_POS(nsp_pkg::SQRT_TOP_BIT - 2 * j)) u_cell (
            .i_clk  (i_clk),
            .i_ld   (ld[ST_SQRT0+j]),
            .i_rem  (sv[j]),
            .i_root (sr[j]),
            .o_rem  (sv[j+1]),
            .o_root (sr[j+1])
        );
    end

    // Rounded division of the root by 512 times the step count.
    logic [nsp_pkg::MAG_W:0]            q_bias;
    logic [nsp_pkg::QUO_W-1:0]          t_div;
    logic [nsp_pkg::QUO_W-1:0]          r_t;
    logic [nsp_pkg::RPROD_W-1:0]        r_prod;
    logic [nsp_pkg::QUO_W-1:0]          est;
    logic [nsp_pkg::QUO_W+nsp_pkg::STEP_W-1:0] est_n;
    logic [nsp_pkg::QUO_W+nsp_pkg::STEP_W-1:0] rem;
    logic [nsp_pkg::QUO_W-1:0]          r_est;
    logic                               r_inc;
    logic [nsp_pkg::QUO_W-1:0]          quo;
    logic [nsp_pkg::MOD_W-1:0]          r_mod33;

    always_comb begin
        q_bias = {1'b0, sr[nsp_pkg::SQRT_CELLS][nsp_pkg::MAG_W-1:0]}
               + ((nsp_pkg::MAG_W+1)'(r_side[ST_MUL-1].n_steps) << 8);
        t_div  = q_bias[nsp_pkg::MAG_W:9];
        est    = nsp_pkg::QUO_W'(r_prod >> nsp_pkg::RECIP_SHIFT);
        est_n  = est * r_side[ST_EST-1].n_steps;
        rem    = {{nsp_pkg::STEP_W{1'b0}}, r_t} - est_n;
        quo    = r_est + nsp_pkg::QUO_W'(r_inc);
    end

    always_ff @(posedge i_clk) begin
        if (ld[ST_MUL]) begin
            r_t    <= t_div;
            r_prod <= t_div * nsp_pkg::recip(r_side[ST_MUL-1].n_steps);
        end
        if (ld[ST_EST]) begin
            r_est <= est;
            r_inc <= rem >= (nsp_pkg::QUO_W+nsp_pkg::STEP_W)'(r_side[ST_EST-1].n_steps);
        end
        if (ld[ST_MOD]) begin
            if (!r_side[ST_MOD-1].mod_en) begin
                r_mod33 <= '0;
            end else if (quo > nsp_pkg::QUO_W'(nsp_pkg::MOD_TOP)) begin
                r_mod33 <= nsp_pkg::MOD_TOP;
            end else begin
                r_mod33 <= quo[nsp_pkg::MOD_W-1:0];
            end
        end
    end

    // Output register: round the angle to the phase width.
    logic [nsp_pkg::ANG_W-1:0] ang_rnd;
    logic [PHASE_BITS-1:0]     r_phase;
    logic [nsp_pkg::MOD_W-1:0] r_mod;

    assign ang_rnd = ca[nsp_pkg::CORDIC_ITERS] + ROUND_HALF;

    always_ff @(posedge i_clk) begin
        if (ld[ST_OUT]) begin
            r_phase <= r_side[ST_OUT-1].zero ? '0 : ang_rnd[nsp_pkg::ANG_W-1 -: PHASE_BITS];
            r_mod   <= r_mod33;
        end
    end

    assign o_wrapped_phase = r_phase;
    assign o_modulation    = r_mod;

endmodule

`default_nettype wire

@@ src/nsp_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// nsp_cordic_cell: one vectoring rotation of the arctangent chain
// Rotates (x, y) toward the positive x axis and accumulates the angle.
// ----------------------------------------------------------------------------
`default_nettype none

module nsp_cordic_cell #(
    parameter int SHIFT = 0
) (
    input  wire                                  i_clk,
    input  wire                                  i_ld,
    input  wire logic signed [nsp_pkg::XY_W-1:0] i_x,
    input  wire logic signed [nsp_pkg::XY_W-1:0] i_y,
    input  wire logic [nsp_pkg::ANG_W-1:0]       i_ang,
    output logic signed [nsp_pkg::XY_W-1:0]      o_x,
    output logic signed [nsp_pkg::XY_W-1:0]      o_y,
    output logic [nsp_pkg::ANG_W-1:0]            o_ang
);

    logic signed [nsp_pkg::XY_W-1:0] dx;
    logic signed [nsp_pkg::XY_W-1:0] dy;
    logic signed [nsp_pkg::XY_W-1:0] n_x;
    logic signed [nsp_pkg::XY_W-1:0] n_y;
    logic [nsp_pkg::ANG_W-1:0]       n_ang;
    logic signed [nsp_pkg::XY_W-1:0] r_x;
    logic signed [nsp_pkg::XY_W-1:0] r_y;
    logic [nsp_pkg::ANG_W-1:0]       r_ang;

    always_comb begin
        dx = i_y >>> SHIFT;
        dy = i_x >>> SHIFT;
        if (!i_y[nsp_pkg::XY_W-1]) begin
            n_x   = i_x + dx;
            n_y   = i_y - dy;
            n_ang = i_ang + nsp_pkg::ATAN_TAB[SHIFT];
        end else begin
            n_x   = i_x - dx;
            n_y   = i_y + dy;
            n_ang = i_ang - nsp_pkg::ATAN_TAB[SHIFT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_ang <= n_ang;
        end
    end

    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_ang = r_ang;

endmodule

`default_nettype wire

@@ src/nsp_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// nsp_sqrt_cell: one digit of the integer square root chain
// Tries one root bit against the remainder and hands both on.
// ----------------------------------------------------------------------------
`default_nettype none

module nsp_sqrt_cell #(
    parameter int BIT_POS = 0
) (
    input  wire                             i_clk,
    input  wire                             i_ld,
    input  wire logic [nsp_pkg::SQ_W-1:0]   i_rem,
    input  wire logic [nsp_pkg::SQ_W-1:0]   i_root,
    output logic [nsp_pkg::SQ_W-1:0]        o_rem,
    output logic [nsp_pkg::SQ_W-1:0]        o_root
);

    localparam logic [nsp_pkg::SQ_W-1:0] BIT = nsp_pkg::SQ_W'(1) << BIT_POS;

    logic [nsp_pkg::SQ_W-1:0] trial;
    logic [nsp_pkg::SQ_W-1:0] n_rem;
    logic [nsp_pkg::SQ_W-1:0] n_root;
    logic [nsp_pkg::SQ_W-1:0] r_rem;
    logic [nsp_pkg::SQ_W-1:0] r_root;

    always_comb begin
        trial = i_root + BIT;
        if (i_rem >= trial) begin
            n_rem  = i_rem - trial;
            n_root = (i_root >> 1) + BIT;
        end else begin
            n_rem  = i_rem;
            n_root = i_root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

`default_nettype wire

@@ src/nsp_checker.sv @@
// ----------------------------------------------------------------------------
// nsp_checker: port-level checks of the phase-shift pixel core
// Watches the handshakes of the top level and is bound to it.
// ----------------------------------------------------------------------------
`default_nettype none

module nsp_checker #(
    parameter int PHASE_BITS = 16
) (
    input wire                            i_clk,
    input wire                            i_rst_n,
    input wire                            o_stall,
    input wire                            o_valid,
    input wire                            i_stall,
    input wire [PHASE_BITS-1:0]           o_wrapped_phase,
    input wire [nsp_pkg::MOD_W-1:0]       o_modulation
);

    // The pipeline only refuses a beat when the result at its end is blocked.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while output is free");

    // Reset leaves the pipeline empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat right after reset");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("result dropped under stall");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> ($stable(o_wrapped_phase) && $stable(o_modulation)))
        else $error("result changed under stall");

endmodule

bind n_step_phase_shift_pixel_core nsp_checker #(.PHASE_BITS(PHASE_BITS)) u_nsp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_wrapped_phase (o_wrapped_phase),
    .o_modulation    (o_modulation)
);

`default_nettype wire

@@ bench/n_step_phase_shift_pixel_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// n_step_phase_shift_pixel_core_tb: self-checking bench of the pixel core
// Drives pixels at several step counts and modulation settings under random
// sender gaps and receiver stalls, and compares every result beat with a
// behavioral phase and modulation predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module n_step_phase_shift_pixel_core_tb;

    localparam int LATENCY   = 35;
    localparam int CYCLE_CAP = 400000;
    localparam logic [nsp_pkg::CFG_IDX_W-1:0] REG_UNUSED = 4'd7;

    typedef logic [nsp_pkg::SAMPLE_W-1:0] t_pixel [nsp_pkg::NUM_SAMPLES];
    typedef struct packed {
        logic [15:0]               phase;
        logic [nsp_pkg::MOD_W-1:0] modulation;
    } t_result;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_valid = 1'b0;
    logic                         i_stall = 1'b0;
    logic [nsp_pkg::SAMPLE_W-1:0] smp [nsp_pkg::NUM_SAMPLES];
    logic                         i_cfg_valid = 1'b0;
    logic [nsp_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [nsp_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    wire                          o_stall, o_valid, o_cfg_ready;
    wire [15:0]                   o_wrapped_phase;
    wire [nsp_pkg::MOD_W-1:0]     o_modulation;

    logic [nsp_pkg::STEP_W-1:0] step_count_reg = nsp_pkg::STEP_RESET;
    logic              mod_enable_reg = 1'b0;
    t_result           expected_results [$];
    int                error_count = 0;
    int                cycle_count = 0;
    int                gap_pct = 0;
    int                stall_pct = 0;

    n_step_phase_shift_pixel_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_sample_0(smp[0]), .i_sample_1(smp[1]), .i_sample_2(smp[2]),
        .i_sample_3(smp[3]), .i_sample_4(smp[4]), .i_sample_5(smp[5]),
        .i_sample_6(smp[6]), .i_sample_7(smp[7]),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_wrapped_phase(o_wrapped_phase), .o_modulation(o_modulation),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    initial for (int k = 0; k < nsp_pkg::NUM_SAMPLES; k++) smp[k] = '0;

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("n_step_phase_shift_pixel_core_tb NOT OK");
            $finish;
        end
    end

    // Receiver stalls are drawn once per cycle.
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic longint shr_arith(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic t_result predict_pixel(t_pixel px);
        int n;
        longint m = 0, d = 0, x, y, dx, dy;
        logic [31:0] ang = '0;
        longint unsigned um, ud, q, md;
        t_result r;
        n = step_count_reg;
        if (n < 3) n = 3;
        if (n > 8) n = 8;
        for (int k = 0; k < n; k++) begin
            m += longint'(px[k]) * longint'(nsp_pkg::SIN_TAB[n-3][k]);
            d += longint'(px[k]) * longint'(nsp_pkg::COS_TAB[n-3][k]);
        end
        r.phase = '0;
        if (m != 0 || d != 0) begin
            x = d * (64'sd1 << 26);
            y = -m * (64'sd1 << 26);
            if (x < 0) begin
                x = -x;
                y = -y;
                ang = nsp_pkg::HALF_TURN;
            end
            for (int i = 0; i < nsp_pkg::CORDIC_ITERS; i++) begin
                dx = shr_arith(y, i);
                dy = shr_arith(x, i);
                if (y >= 0) begin
                    x += dx; y -= dy; ang += nsp_pkg::ATAN_TAB[i];
                end else begin
                    x -= dx; y += dy; ang -= nsp_pkg::ATAN_TAB[i];
                end
            end
            ang += 32'h0000_8000;
            r.phase = ang[31:16];
        end
        r.modulation = '0;
        if (mod_enable_reg) begin
            um = (m < 0) ? -m : m;
            ud = (d < 0) ? -d : d;
            q = root_floor(um * um + ud * ud);
            md = (q + n * 256) / (n * 512);
            r.modulation = (md > nsp_pkg::MOD_TOP) ? nsp_pkg::MOD_TOP
                                                   : md[nsp_pkg::MOD_W-1:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected beat", o_wrapped_phase, 0);
            end else begin
                want = expected_results.pop_front();
                if (o_wrapped_phase !== want.phase)
                    report_mismatch("phase", o_wrapped_phase, want.phase);
                if (o_modulation !== want.modulation)
                    report_mismatch("modulation", o_modulation, want.modulation);
            end
        end
    end

    // Valid stays high after a beat so that the next one can follow at once;
    // it drops only for sender gaps and when the pipe is drained.
    task automatic send_pixel(t_pixel px);
        if ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < gap_pct);
        end
        i_valid <= 1'b1;
        for (int k = 0; k < nsp_pkg::NUM_SAMPLES; k++) smp[k] <= px[k];
        do @(posedge i_clk); while (o_stall);
        expected_results.insert(expected_results.size(), predict_pixel(px));
    endtask

    task automatic drain_pipe();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [nsp_pkg::CFG_IDX_W-1:0] idx,
                             logic [nsp_pkg::CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == nsp_pkg::REG_STEP_COUNT) step_count_reg = val[nsp_pkg::STEP_W-1:0];
        else if (idx == nsp_pkg::REG_MOD_ENABLE) mod_enable_reg = val[0];
        @(posedge i_clk);
    endtask

    function automatic t_pixel fill_pixel(int v);
        t_pixel px;
        for (int k = 0; k < nsp_pkg::NUM_SAMPLES; k++) px[k] = v[nsp_pkg::SAMPLE_W-1:0];
        return px;
    endfunction

    function automatic t_pixel random_pixel();
        t_pixel px;
        int kind = $urandom_range(9);
        for (int k = 0; k < nsp_pkg::NUM_SAMPLES; k++) begin
            if (kind == 0) px[k] = $urandom_range(1) ? 8'hFF : 8'h00;
            else px[k] = 8'($urandom_range(255));
        end
        return px;
    endfunction

    task automatic test_directed();
        t_pixel px;
        write_reg(nsp_pkg::REG_MOD_ENABLE, 8'd1);
        for (int n = 3; n <= 8; n++) begin
            drain_pipe();
            write_reg(nsp_pkg::REG_STEP_COUNT, n[7:0]);
            send_pixel(fill_pixel(0));      // zero vector
            send_pixel(fill_pixel(255));    // zero vector at full scale
            px = fill_pixel(0); px[0] = 8'd255;
            send_pixel(px);                 // positive real axis
            px = fill_pixel(255); px[0] = 8'd0;
            send_pixel(px);                 // negative real axis
        end
        drain_pipe();
        write_reg(nsp_pkg::REG_STEP_COUNT, 8'd4);
        px = fill_pixel(0); px[1] = 8'd255;
        send_pixel(px);
        px = fill_pixel(0); px[3] = 8'd255;
        send_pixel(px);
        drain_pipe();
        // Out-of-range step counts saturate; unknown indexes are ignored.
        write_reg(nsp_pkg::REG_STEP_COUNT, 8'd0);
        send_pixel(random_pixel());
        drain_pipe();
        write_reg(nsp_pkg::REG_STEP_COUNT, 8'd15);
        write_reg(REG_UNUSED, 8'hFF);
        send_pixel(random_pixel());
        drain_pipe();
        write_reg(nsp_pkg::REG_MOD_ENABLE, 8'd0);
        send_pixel(random_pixel());
    endtask

    task automatic test_random(int count);
        drain_pipe();
        write_reg(nsp_pkg::REG_STEP_COUNT, 8'($urandom_range(15)));
        write_reg(nsp_pkg::REG_MOD_ENABLE, 8'($urandom_range(1)));
        for (int i = 0; i < count; i++) send_pixel(random_pixel());
    endtask

    task automatic test_idle_phases();
        int gaps [4] = '{0, 47, 0, 35};
        int stalls [4] = '{0, 0, 47, 35};
        for (int p = 0; p < 4; p++) begin
            gap_pct = gaps[p];
            stall_pct = stalls[p];
            for (int s = 0; s < 4; s++) test_random(70);
        end
        gap_pct = 0;
        stall_pct = 0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_idle_phases();
        drain_pipe();
        if (error_count == 0) begin
            $display("n_step_phase_shift_pixel_core_tb OK");
        end else begin
            $display("n_step_phase_shift_pixel_core_tb NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
src/nsp_pkg.sv
src/nsp_cordic_cell.sv
src/nsp_sqrt_cell.sv
src/n_step_phase_shift_pixel_core.sv
src/nsp_checker.sv
bench/n_step_phase_shift_pixel_core_tb.sv
